// File: hw/rtl/icts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package icts_pkg;

  localparam int NUM_CORES = 4;
  localparam int NUM_BINS  = 10;

  localparam int TIME_W    = 48;
  localparam int CRED_W    = 8;
  localparam int CFG_W     = 32;
  localparam int CORE_ID_W = 4;
  localparam int HIT_W     = 6;
  localparam int OUT_W     = 2;
  localparam int CORE_W    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int BND_W     = CFG_W + $clog2(NUM_BINS + 1);

  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_BIN_WIDTH     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INIT_CREDITS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REFILL_PERIOD = 2'd2;

  localparam logic [CFG_W-1:0]  BIN_WIDTH_RST     = 32'd1000;
  localparam logic [CRED_W-1:0] INIT_CREDITS_RST  = 8'd4;
  localparam logic [CFG_W-1:0]  REFILL_PERIOD_RST = 32'd100000;

  localparam logic FUNC_SHAPE  = 1'b0;
  localparam logic FUNC_REFILL = 1'b1;

  localparam logic [OUT_W-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUT_W-1:0] OUTCOME_UNMOD = 2'd1;
  localparam logic [OUT_W-1:0] OUTCOME_DEFER = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WB
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0]  bin_width;
    logic [CRED_W-1:0] init_credits;
    logic [CFG_W-1:0]  refill_period;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]                  last;
    logic [NUM_BINS-1:0][CRED_W-1:0]    cred;
  } row_t;

endpackage

`default_nettype wire

// File: hw/rtl/icts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module icts_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/icts_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module icts_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [icts_pkg::APB_AW-1:0]  paddr,
  input  wire logic [icts_pkg::APB_DW-1:0]  pwdata,
  output logic      [icts_pkg::APB_DW-1:0]  prdata,
  output logic                              pready,
  output icts_pkg::cfg_t                    cfg_o
);

  icts_pkg::cfg_t                   cfg_q;
  logic [icts_pkg::REG_IDX_W-1:0]   idx;
  logic                             wr_en;

  assign idx    = paddr[icts_pkg::APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bin_width     <= icts_pkg::BIN_WIDTH_RST;
      cfg_q.init_credits  <= icts_pkg::INIT_CREDITS_RST;
      cfg_q.refill_period <= icts_pkg::REFILL_PERIOD_RST;
    end else if (wr_en) begin
      unique case (idx)
        icts_pkg::REG_BIN_WIDTH:     cfg_q.bin_width     <= pwdata;
        icts_pkg::REG_INIT_CREDITS:  cfg_q.init_credits  <= pwdata[icts_pkg::CRED_W-1:0];
        icts_pkg::REG_REFILL_PERIOD: cfg_q.refill_period <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      icts_pkg::REG_BIN_WIDTH:     prdata = cfg_q.bin_width;
      icts_pkg::REG_INIT_CREDITS:  prdata = icts_pkg::APB_DW'(cfg_q.init_credits);
      icts_pkg::REG_REFILL_PERIOD: prdata = cfg_q.refill_period;
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/interarrival_credit_traffic_shaper.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-core inter-arrival credit shaper.
// Requests: start with func_i/core_id_i/time_now_i, taken when busy is low.
// A refill request is absorbed in its accept cycle; busy stays low and no
// result follows. A shaping request for a valid core holds busy high
// through row read, bin select and write-back, and its result shows on
// send_time_o/bin_hit_o/outcome_o with done_o high for one cycle; a new
// request may be taken while done_o is high, but not before, since each
// shaping request is a read-modify-write of the per-core row in the
// state RAM.
// Requests for cores beyond the core count are dropped with no result.
// Config is an APB slave, pready always high: 0x0 bin width,
// 0x4 init credits, 0x8 refill period.
// Reset restores register defaults and reads every row as zero credits and
// zero last-send time; no clearing pass is needed. A refill marks all rows
// stale so they read the refill credit and time until written back.
// The receiver cannot stall: done_o is a single-cycle strobe.

module interarrival_credit_traffic_shaper (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             func_i,
  input  wire logic [icts_pkg::CORE_ID_W-1:0]   core_id_i,
  input  wire logic [icts_pkg::TIME_W-1:0]      time_now_i,
  output logic                                  done_o,
  output logic      [icts_pkg::TIME_W-1:0]      send_time_o,
  output logic      [icts_pkg::HIT_W-1:0]       bin_hit_o,
  output logic      [icts_pkg::OUT_W-1:0]       outcome_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [icts_pkg::APB_AW-1:0]      paddr,
  input  wire logic [icts_pkg::APB_DW-1:0]      pwdata,
  output logic      [icts_pkg::APB_DW-1:0]      prdata,
  output logic                                  pready
);

  localparam int NB = icts_pkg::NUM_BINS;
  localparam int NC = icts_pkg::NUM_CORES;

  icts_pkg::cfg_t   cfg;
  icts_pkg::state_e state_q, state_d;

  logic accept, core_ok, take_shape, take_refill;
  logic ram_re, ram_we;

  icts_pkg::row_t   ram_rdata, row_eff, wrow;

  logic [NC-1:0]                     valid_q;
  logic [icts_pkg::CRED_W-1:0]       snap_cred_q;
  logic [icts_pkg::TIME_W-1:0]       snap_time_q;
  logic [icts_pkg::TIME_W-1:0]       next_refill_q;

  logic [icts_pkg::CORE_W-1:0]       core_q;
  logic [icts_pkg::TIME_W-1:0]       now_q;
  logic [icts_pkg::TIME_W-1:0]       last_q;
  logic [icts_pkg::TIME_W-1:0]       iv0_q;
  logic [icts_pkg::TIME_W-1:0]       iv0_d;
  logic [NB-1:0][icts_pkg::CRED_W-1:0] cred_q;

  logic [icts_pkg::BND_W-1:0]        bound [NB];
  logic [icts_pkg::BND_W-1:0]        lower [NB];
  logic [NB-1:0]                     cand;
  logic                              found;
  logic [NB-1:0]                     hit_oh_d, hit_oh_q;
  logic [icts_pkg::HIT_W-1:0]        hit_idx_d, hit_idx_q;
  logic [icts_pkg::TIME_W-1:0]       lower_sel, ivl_d, ivl_q;
  logic [icts_pkg::OUT_W-1:0]        oc_d, oc_q;
  logic [icts_pkg::TIME_W-1:0]       send;

  logic                              done_q;
  logic [icts_pkg::TIME_W-1:0]       send_time_q;
  logic [icts_pkg::HIT_W-1:0]        bin_hit_q;
  logic [icts_pkg::OUT_W-1:0]        outcome_q;

  icts_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  icts_ram #(
    .Width ($bits(icts_pkg::row_t)),
    .Depth (NC)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (core_q),
    .wdata_i (wrow),
    .re_i    (ram_re),
    .raddr_i (core_id_i[icts_pkg::CORE_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign accept      = start && !busy;
  assign core_ok     = ({1'b0, core_id_i} < (icts_pkg::CORE_ID_W + 1)'(NC));
  assign take_refill = accept && (func_i == icts_pkg::FUNC_REFILL);
  assign take_shape  = accept && (func_i == icts_pkg::FUNC_SHAPE) && core_ok;

  // FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      icts_pkg::ST_IDLE: if (take_shape) state_d = icts_pkg::ST_READ;
      icts_pkg::ST_READ: state_d = icts_pkg::ST_EVAL;
      icts_pkg::ST_EVAL: state_d = icts_pkg::ST_WB;
      icts_pkg::ST_WB:   state_d = icts_pkg::ST_IDLE;
      default:           state_d = icts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state_q != icts_pkg::ST_IDLE);
    ram_re = take_shape;
    ram_we = (state_q == icts_pkg::ST_WB);
  end

  // stale rows read as the last refill snapshot
  always_comb begin
    row_eff = ram_rdata;
    if (!valid_q[core_q]) begin
      row_eff.last = snap_time_q;
      for (int b = 0; b < NB; b++) begin
        row_eff.cred[b] = snap_cred_q;
      end
    end
    iv0_d = (now_q >= row_eff.last) ? (now_q - row_eff.last) : '0;
  end

  for (genvar g = 0; g < NB; g++) begin : g_bin
    assign bound[g] = icts_pkg::BND_W'(g + 1) * icts_pkg::BND_W'(cfg.bin_width);
    if (g == 0) begin : g_first
      assign lower[g] = '0;
    end else begin : g_rest
      assign lower[g] = bound[g-1];
    end
    assign cand[g] = (iv0_q < icts_pkg::TIME_W'(bound[g])) && (cred_q[g] != '0);
  end

  always_comb begin
    found     = 1'b0;
    hit_oh_d  = '0;
    hit_idx_d = icts_pkg::HIT_W'(NB);
    lower_sel = '0;
    for (int b = 0; b < NB; b++) begin
      if (cand[b] && !found) begin
        found       = 1'b1;
        hit_oh_d[b] = 1'b1;
        hit_idx_d   = icts_pkg::HIT_W'(b);
        lower_sel   = icts_pkg::TIME_W'(lower[b]);
      end
    end
    ivl_d = (iv0_q > lower_sel) ? iv0_q : lower_sel;
    if (found) begin
      oc_d = icts_pkg::OUTCOME_HIT;
    end else if (iv0_q > icts_pkg::TIME_W'(bound[NB-1])) begin
      oc_d = icts_pkg::OUTCOME_UNMOD;
    end else begin
      oc_d = icts_pkg::OUTCOME_DEFER;
    end
  end

  always_comb begin
    case (oc_q)
      icts_pkg::OUTCOME_HIT:   send = last_q + ivl_q;
      icts_pkg::OUTCOME_UNMOD: send = now_q;
      default:                 send = next_refill_q;
    endcase
    wrow.last = send;
    for (int b = 0; b < NB; b++) begin
      wrow.cred[b] = cred_q[b] - (hit_oh_q[b] ? icts_pkg::CRED_W'(1) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= icts_pkg::ST_IDLE;
      valid_q       <= '0;
      snap_cred_q   <= '0;
      snap_time_q   <= '0;
      next_refill_q <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == icts_pkg::ST_WB);
      if (take_refill) begin
        valid_q       <= '0;
        snap_cred_q   <= cfg.init_credits;
        snap_time_q   <= time_now_i;
        next_refill_q <= time_now_i + icts_pkg::TIME_W'(cfg.refill_period);
      end else if (ram_we) begin
        valid_q[core_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_shape) begin
      core_q <= core_id_i[icts_pkg::CORE_W-1:0];
      now_q  <= time_now_i;
    end
    if (state_q == icts_pkg::ST_READ) begin
      last_q <= row_eff.last;
      cred_q <= row_eff.cred;
      iv0_q  <= iv0_d;
    end
    if (state_q == icts_pkg::ST_EVAL) begin
      hit_oh_q  <= hit_oh_d;
      hit_idx_q <= hit_idx_d;
      ivl_q     <= ivl_d;
      oc_q      <= oc_d;
    end
    if (state_q == icts_pkg::ST_WB) begin
      send_time_q <= send;
      bin_hit_q   <= hit_idx_q;
      outcome_q   <= oc_q;
    end
  end

  assign done_o      = done_q;
  assign send_time_o = send_time_q;
  assign bin_hit_o   = bin_hit_q;
  assign outcome_o   = outcome_q;

  a_shape_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_shape |-> ##4 done_o)
    else $error("shaping request gave no result");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == icts_pkg::ST_WB))
    else $error("result strobe without write-back");

  a_hit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((outcome_o == icts_pkg::OUTCOME_HIT) == (bin_hit_o != icts_pkg::HIT_W'(NB))))
    else $error("bin index disagrees with outcome");

  a_refill_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_refill |=> (valid_q == '0))
    else $error("refill left a row marked current");

endmodule

`default_nettype wire
